// ===== src/mbps_pkg.sv =====
// Shared constants, types and helpers for the masked byte pattern search.
package mbps_pkg;

    // Window depth and position counter width
    localparam int MAX_PATTERN_BYTES = 16;
    localparam int POSITION_BITS     = 24;

    // Fixed register geometry
    localparam int REG_PATTERN_BYTES = 16;
    localparam int REG_DATA_BITS     = 64;
    localparam int REG_ADDR_BITS     = 6;
    localparam int REG_INDEX_BITS    = 3;
    localparam int REG_LENGTH_BITS   = 5;
    localparam int REG_POS_BITS      = 24;

    // Derived widths
    localparam int LEN_BITS = $clog2(MAX_PATTERN_BYTES + 1);
    localparam int CMP_BITS = 33;

    // Register indexes (byte address = 8 * index)
    localparam logic [REG_INDEX_BITS-1:0] REG_PATTERN_LOW     = 3'd0;
    localparam logic [REG_INDEX_BITS-1:0] REG_PATTERN_HIGH    = 3'd1;
    localparam logic [REG_INDEX_BITS-1:0] REG_CARE_MASK_LOW   = 3'd2;
    localparam logic [REG_INDEX_BITS-1:0] REG_CARE_MASK_HIGH  = 3'd3;
    localparam logic [REG_INDEX_BITS-1:0] REG_PATTERN_LENGTH  = 3'd4;
    localparam logic [REG_INDEX_BITS-1:0] REG_SEARCH_BACKWARD = 3'd5;
    localparam logic [REG_INDEX_BITS-1:0] REG_START_POSITION  = 3'd6;
    localparam logic [REG_INDEX_BITS-1:0] REG_MAX_DISTANCE    = 3'd7;

    // Configuration seen by the datapath
    typedef struct packed {
        logic [REG_DATA_BITS-1:0]   pattern_low;
        logic [REG_DATA_BITS-1:0]   pattern_high;
        logic [REG_DATA_BITS-1:0]   care_mask_low;
        logic [REG_DATA_BITS-1:0]   care_mask_high;
        logic [REG_LENGTH_BITS-1:0] pattern_length;
        logic                       search_backward;
        logic [REG_POS_BITS-1:0]    start_position;
        logic [REG_POS_BITS-1:0]    max_distance;
    } t_cfg;

    // Pick byte i out of a low/high register pair; bytes past the pair read as zero
    function automatic logic [7:0] reg_byte(input logic [REG_DATA_BITS-1:0] lo,
                                            input logic [REG_DATA_BITS-1:0] hi,
                                            input int unsigned idx);
        logic [7:0] b;
        b = 8'h00;
        if (idx < 8) begin
            b = lo[8*(idx % 8) +: 8];
        end else if (idx < REG_PATTERN_BYTES) begin
            b = hi[8*(idx % 8) +: 8];
        end
        return b;
    endfunction

endpackage

// ===== src/mbps_cell.sv =====
// One window cell: holds a buffer byte and compares the byte it takes next.
module mbps_cell
    import mbps_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_shift,
    input  logic       i_clear,
    input  logic [7:0] i_byte,
    input  logic [7:0] i_pat,
    input  logic [7:0] i_mask,
    output logic [7:0] o_byte,
    output logic       o_hit
);

    logic [7:0] r_byte;
    logic [7:0] n_byte;

    // Take the neighbor's byte on a shift, drop the buffer on its end
    always_comb begin
        n_byte = r_byte;
        if (i_clear) begin
            n_byte = 8'h00;
        end else if (i_shift) begin
            n_byte = i_byte;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_byte <= 8'h00;
        end else begin
            r_byte <= n_byte;
        end
    end

    // Compare the incoming byte, so the hit belongs to the shifted window
    assign o_hit  = ((i_byte ^ i_pat) & i_mask) == 8'h00;
    assign o_byte = r_byte;

endmodule

// ===== src/mbps_regs.sv =====
// APB-style configuration register file for the pattern search.
module mbps_regs
    import mbps_pkg::*;
(
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     psel,
    input  logic                     penable,
    input  logic                     pwrite,
    input  logic [REG_ADDR_BITS-1:0] paddr,
    input  logic [REG_DATA_BITS-1:0] pwdata,
    output logic [REG_DATA_BITS-1:0] prdata,
    output logic                     pready,
    output t_cfg                     o_cfg
);

    t_cfg                      r_cfg;
    logic                      wr_en;
    logic [REG_INDEX_BITS-1:0] index;

    assign pready = 1'b1;
    assign wr_en  = psel & penable & pwrite;
    assign index  = paddr[REG_ADDR_BITS-1 -: REG_INDEX_BITS];

    // Write the addressed register on the access phase
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= '{pattern_length: REG_LENGTH_BITS'(1), default: '0};
        end else if (wr_en) begin
            case (index)
                REG_PATTERN_LOW:     r_cfg.pattern_low     <= pwdata;
                REG_PATTERN_HIGH:    r_cfg.pattern_high    <= pwdata;
                REG_CARE_MASK_LOW:   r_cfg.care_mask_low   <= pwdata;
                REG_CARE_MASK_HIGH:  r_cfg.care_mask_high  <= pwdata;
                REG_PATTERN_LENGTH:  r_cfg.pattern_length  <= pwdata[REG_LENGTH_BITS-1:0];
                REG_SEARCH_BACKWARD: r_cfg.search_backward <= pwdata[0];
                REG_START_POSITION:  r_cfg.start_position  <= pwdata[REG_POS_BITS-1:0];
                REG_MAX_DISTANCE:    r_cfg.max_distance    <= pwdata[REG_POS_BITS-1:0];
                default: ;
            endcase
        end
    end

    // Read back the addressed register
    always_comb begin
        case (index)
            REG_PATTERN_LOW:     prdata = r_cfg.pattern_low;
            REG_PATTERN_HIGH:    prdata = r_cfg.pattern_high;
            REG_CARE_MASK_LOW:   prdata = r_cfg.care_mask_low;
            REG_CARE_MASK_HIGH:  prdata = r_cfg.care_mask_high;
            REG_PATTERN_LENGTH:  prdata = REG_DATA_BITS'(r_cfg.pattern_length);
            REG_SEARCH_BACKWARD: prdata = REG_DATA_BITS'(r_cfg.search_backward);
            REG_START_POSITION:  prdata = REG_DATA_BITS'(r_cfg.start_position);
            REG_MAX_DISTANCE:    prdata = REG_DATA_BITS'(r_cfg.max_distance);
            default:             prdata = '0;
        endcase
    end

    assign o_cfg = r_cfg;

endmodule

// ===== src/masked_byte_pattern_search.sv =====
// Top level of the masked byte pattern search: window chain, match tracking, result register.
//
// Usage:
//  The input channel (i_valid, o_stall, i_data_byte, i_last_byte) moves one buffer byte per
//  transfer; i_last_byte marks the final byte. Each byte enters a chain of window cells, one
//  cell per pattern byte, and every cell compares its byte with its pattern byte in parallel.
//  The result channel (o_valid, i_stall, o_found, o_match_position) carries one result per
//  buffer, loaded into the result register on the transfer of the last byte when it is free.
//  The block takes one byte per cycle while o_stall is low. A result that waits on a stalling
//  receiver moves to a second result register, so bytes keep flowing; o_stall rises only while
//  both result registers are full, and it comes from a register, not from i_stall.
//  Configuration goes through the APB-style port, 64-bit registers at byte address 8 * index;
//  the user writes them only while no buffer is in flight; the block does not enforce this.
//  Forward mode reports the first match at or after start_position; backward mode the highest
//  match in [start_position - max_distance, start_position], the lower bound held at zero.
//  Reset (i_rst_n low, synchronous) clears the window, position count, held match and result
//  valid flags, and sets all registers to zero except pattern_length, which reads 1.
module masked_byte_pattern_search
    import mbps_pkg::*;
(
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    // Configuration port
    input  logic                     psel,
    input  logic                     penable,
    input  logic                     pwrite,
    input  logic [REG_ADDR_BITS-1:0] paddr,
    input  logic [REG_DATA_BITS-1:0] pwdata,
    output logic [REG_DATA_BITS-1:0] prdata,
    output logic                     pready,
    // Byte input
    input  logic                     i_valid,
    output logic                     o_stall,
    input  logic [7:0]               i_data_byte,
    input  logic                     i_last_byte,
    // Result output
    output logic                     o_valid,
    input  logic                     i_stall,
    output logic                     o_found,
    output logic [REG_POS_BITS-1:0]  o_match_position
);

    localparam logic [POSITION_BITS-1:0] POS_MAX = '1;

    t_cfg cfg;

    mbps_regs u_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (cfg)
    );

    // Handshakes
    logic in_xfer;
    logic out_xfer;

    assign in_xfer  = i_valid & ~o_stall;
    assign out_xfer = o_valid & ~i_stall;

    // Clamp the pattern length into 1..MAX_PATTERN_BYTES
    logic [LEN_BITS-1:0] eff_len;

    always_comb begin
        if (cfg.pattern_length == '0) begin
            eff_len = LEN_BITS'(1);
        end else if (int'(cfg.pattern_length) > MAX_PATTERN_BYTES) begin
            eff_len = LEN_BITS'(MAX_PATTERN_BYTES);
        end else begin
            eff_len = LEN_BITS'(cfg.pattern_length);
        end
    end

    // Cell k holds the k-th newest byte and compares against pattern byte len-1-k
    logic [7:0] cell_pat  [MAX_PATTERN_BYTES];
    logic [7:0] cell_mask [MAX_PATTERN_BYTES];

    always_comb begin
        for (int k = 0; k < MAX_PATTERN_BYTES; k++) begin
            cell_pat[k]  = 8'h00;
            cell_mask[k] = 8'h00;
            if (k < int'(eff_len)) begin
                cell_pat[k]  = reg_byte(cfg.pattern_low, cfg.pattern_high,
                                        int'(eff_len) - 1 - k);
                cell_mask[k] = reg_byte(cfg.care_mask_low, cfg.care_mask_high,
                                        int'(eff_len) - 1 - k);
            end
        end
    end

    // Window chain
    logic [7:0]                   chain [MAX_PATTERN_BYTES+1];
    logic [MAX_PATTERN_BYTES-1:0] hits;
    logic                         clear_buf;

    assign chain[0]  = i_data_byte;
    assign clear_buf = in_xfer & i_last_byte;

    for (genvar k = 0; k < MAX_PATTERN_BYTES; k++) begin : g_cell
        mbps_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_shift (in_xfer),
            .i_clear (clear_buf),
            .i_byte  (chain[k]),
            .i_pat   (cell_pat[k]),
            .i_mask  (cell_mask[k]),
            .o_byte  (chain[k+1]),
            .o_hit   (hits[k])
        );
    end

    // Per-buffer tracking
    logic [POSITION_BITS-1:0] r_seen;
    logic [POSITION_BITS-1:0] n_seen;
    logic                     r_held;
    logic                     n_held;
    logic [POSITION_BITS-1:0] r_held_pos;
    logic [POSITION_BITS-1:0] n_held_pos;

    logic [CMP_BITS-1:0] seen_ext;
    logic [CMP_BITS-1:0] len_m1;
    logic [CMP_BITS-1:0] cand_pos;
    logic [CMP_BITS-1:0] start_ext;
    logic [CMP_BITS-1:0] dist_ext;
    logic [CMP_BITS-1:0] low_bound;
    logic                seen_ok;
    logic                window_hit;
    logic                take;

    // Candidate start position and the backward window bounds
    always_comb begin
        seen_ext   = CMP_BITS'(r_seen);
        len_m1     = CMP_BITS'(eff_len) - CMP_BITS'(1);
        cand_pos   = seen_ext - len_m1;
        start_ext  = CMP_BITS'(cfg.start_position);
        dist_ext   = CMP_BITS'(cfg.max_distance);
        low_bound  = (start_ext >= dist_ext) ? (start_ext - dist_ext) : '0;
        seen_ok    = (r_seen < POS_MAX) && (seen_ext >= len_m1);
        window_hit = seen_ok && (&hits);
        if (cfg.search_backward) begin
            take = window_hit && (cand_pos >= low_bound) && (cand_pos <= start_ext);
        end else begin
            take = window_hit && !r_held && (cand_pos >= start_ext);
        end
    end

    // Update the held match and the byte count for this byte
    always_comb begin
        n_held     = r_held;
        n_held_pos = r_held_pos;
        n_seen     = r_seen;
        if (take) begin
            n_held     = 1'b1;
            n_held_pos = cand_pos[POSITION_BITS-1:0];
        end
        if (r_seen < POS_MAX) begin
            n_seen = r_seen + POSITION_BITS'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_seen     <= '0;
            r_held     <= 1'b0;
            r_held_pos <= '0;
        end else if (in_xfer) begin
            if (i_last_byte) begin
                r_seen     <= '0;
                r_held     <= 1'b0;
                r_held_pos <= '0;
            end else begin
                r_seen     <= n_seen;
                r_held     <= n_held;
                r_held_pos <= n_held_pos;
            end
        end
    end

    // Result register plus a second one that catches a result while the first waits
    logic                    r_out_valid;
    logic                    r_found;
    logic [REG_POS_BITS-1:0] r_match_pos;
    logic                    r_skid_valid;
    logic                    r_skid_found;
    logic [REG_POS_BITS-1:0] r_skid_pos;
    logic                    res_found;
    logic [REG_POS_BITS-1:0] res_pos;
    logic                    out_free;

    assign res_found = n_held;
    assign res_pos   = n_held ? REG_POS_BITS'(n_held_pos) : '0;
    assign out_free  = out_xfer | ~r_out_valid;
    assign o_stall   = r_skid_valid;

    // Load on the last byte, drop once transferred, refill from the second register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (out_free) begin
            if (r_skid_valid) begin
                r_out_valid  <= 1'b1;
                r_skid_valid <= 1'b0;
            end else begin
                r_out_valid  <= clear_buf;
            end
        end else if (clear_buf) begin
            r_skid_valid <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_free) begin
            if (r_skid_valid) begin
                r_found     <= r_skid_found;
                r_match_pos <= r_skid_pos;
            end else if (clear_buf) begin
                r_found     <= res_found;
                r_match_pos <= res_pos;
            end
        end else if (clear_buf) begin
            r_skid_found <= res_found;
            r_skid_pos   <= res_pos;
        end
    end

    assign o_valid          = r_out_valid;
    assign o_found          = r_found;
    assign o_match_position = r_match_pos;

endmodule
